[rtl/dcc_packet_word_packer_top_defines.svh]
// Assertion macros for the packet word packer.
`ifndef DCC_PACKET_WORD_PACKER_TOP_DEFINES_SVH
`define DCC_PACKET_WORD_PACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define DCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/dcc_pkg.sv]
// Types and codes shared by the packet word packer.
package dcc_pkg;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_ADD_END = 2'd1;
   localparam logic [1:0] ACT_END     = 2'd2;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic        last_word;
      logic        truncated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SHIFT,
      ST_SEND
   } state_type;

endpackage

[rtl/dcc_packet_word_packer_top.sv]
// Packet word packer: byte collection, XOR checksum and 32-bit word output.
//
//   channel | direction | payload             | transfer
//   req     | in        | dcc_pkg::req_type   | req_valid & req_ready
//   rsp     | out       | dcc_pkg::rsp_type   | rsp_valid & rsp_ready
//
// An end item streams count byte, stored bytes, checksum and padding one
// byte at a time through the word shift register: each byte is read from
// memory, then shifted, and a word is sent once it holds four bytes.
// Reset is synchronous and clears count, checksum, overflow flag and state.
// req_ready is low from an end item that closes a non-empty packet until the
// last word is transferred; a stalled rsp holds its word.
`include "dcc_packet_word_packer_top_defines.svh"

module dcc_packet_word_packer_top #(
   parameter int MAX_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dcc_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dcc_pkg::rsp_type rsp_item
);

   localparam int DEPTH = MAX_BYTES - 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_BYTES);
   localparam int KW    = $clog2(MAX_BYTES + 4);

   logic [dcc_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [dcc_pkg::BYTE_W-1:0] rd_q_ff;

   dcc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [dcc_pkg::BYTE_W-1:0]  xor_ff, xor_in;
   logic                        ovf_ff, ovf_in;
   logic [KW-1:0]               k_ff, k_in;
   logic [dcc_pkg::WORD_W-1:0]  word_ff, word_in;
   logic                        last_ff, last_in;

   logic                        req_xfer, rsp_xfer;
   logic                        is_add, is_end, has_room, wr_en;
   logic [CW-1:0]               count_add;
   logic [KW-1:0]               count_k, rd_k;
   logic [dcc_pkg::BYTE_W-1:0]  sel_byte;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign is_add    = (req_item.action == dcc_pkg::ACT_ADD) ||
                      (req_item.action == dcc_pkg::ACT_ADD_END);
   assign is_end    = (req_item.action == dcc_pkg::ACT_ADD_END) ||
                      (req_item.action == dcc_pkg::ACT_END);
   assign has_room  = (count_ff < CW'(DEPTH));
   assign wr_en     = req_xfer && is_add && has_room;
   assign count_add = wr_en ? count_ff + CW'(1) : count_ff;
   assign count_k   = KW'(count_ff);
   assign rd_k      = k_ff - KW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_item.data_byte;
      end
      rd_q_ff <= mem[rd_k[AW-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dcc_pkg::ST_IDLE: begin
            if (req_xfer && is_end && (count_add != '0)) begin
               state_in = dcc_pkg::ST_FETCH;
            end
         end
         dcc_pkg::ST_FETCH: state_in = dcc_pkg::ST_SHIFT;
         dcc_pkg::ST_SHIFT: begin
            state_in = (k_ff[1:0] == 2'd3) ? dcc_pkg::ST_SEND : dcc_pkg::ST_FETCH;
         end
         dcc_pkg::ST_SEND: begin
            if (rsp_xfer) begin
               state_in = last_ff ? dcc_pkg::ST_IDLE : dcc_pkg::ST_FETCH;
            end
         end
         default: state_in = dcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         dcc_pkg::ST_IDLE: req_ready = 1'b1;
         dcc_pkg::ST_SEND: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (k_ff == '0) begin
         sel_byte = dcc_pkg::BYTE_W'(count_ff) + dcc_pkg::BYTE_W'(1);
      end else if (k_ff <= count_k) begin
         sel_byte = rd_q_ff;
      end else if (k_ff == count_k + KW'(1)) begin
         sel_byte = xor_ff;
      end else begin
         sel_byte = '0;
      end
   end

   always_comb begin
      count_in = count_add;
      xor_in   = xor_ff;
      ovf_in   = ovf_ff;
      k_in     = k_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      if (wr_en) begin
         xor_in = xor_ff ^ req_item.data_byte;
      end
      if (req_xfer && is_add && !has_room) begin
         ovf_in = 1'b1;
      end
      if (state_ff == dcc_pkg::ST_IDLE && req_xfer && is_end) begin
         k_in = '0;
         if (count_add == '0) begin
            xor_in = '0;
            ovf_in = 1'b0;
         end
      end
      if (state_ff == dcc_pkg::ST_SHIFT) begin
         word_in = {word_ff[dcc_pkg::WORD_W-dcc_pkg::BYTE_W-1:0], sel_byte};
         last_in = (k_ff >= count_k + KW'(1));
         k_in    = k_ff + KW'(1);
      end
      if (state_ff == dcc_pkg::ST_SEND && rsp_xfer && last_ff) begin
         count_in = '0;
         xor_in   = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcc_pkg::ST_IDLE;
         count_ff <= '0;
         xor_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         ovf_ff   <= ovf_in;
      end
      k_ff    <= k_in;
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_item.out_word  = word_ff;
   assign rsp_item.last_word = last_ff;
   assign rsp_item.truncated = ovf_ff;

   `DCC_ASSERT_NOW(a_one_side, clock, reset, rsp_valid, !req_ready,
      "input taken while a word is pending")
   `DCC_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(DEPTH),
      "byte count beyond store depth")
   `DCC_ASSERT_NEXT(a_last_frees, clock, reset, rsp_xfer && rsp_item.last_word,
      req_ready && count_ff == '0 && !ovf_ff,
      "packet state not cleared after final word")

endmodule
